@@ sv/delta_list_task_scheduler_macros.svh @@
// Assertion macros used by the delta list scheduler controller.
// Depends on nothing; included by files that carry assertions.
`ifndef DELTA_LIST_TASK_SCHEDULER_MACROS_SVH
`define DELTA_LIST_TASK_SCHEDULER_MACROS_SVH

// An implication checked on every rising clock edge outside reset.
`define DLTS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// An implication whose consequent is checked in the next cycle.
`define DLTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/dlts_pkg.sv @@
// Shared types and constants of the delta list scheduler.
// Depends on nothing; imported by the controller, datapath and top level.
package dlts_pkg;

	localparam int DelayW = 24;
	localparam int IdW = 8;
	localparam logic [DelayW-1:0] DelayMax = {DelayW{1'b1}};
	localparam int ResultMax = 16;

	typedef enum logic [1:0] {
		ACT_TICK = 2'd0,
		ACT_ADD = 2'd1,
		ACT_DEL = 2'd2,
		ACT_DISP = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_FULL = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// Datapath operations issued by the controller.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_TICK_DEC,
		OP_INS_SETUP,
		OP_INS_SCAN,
		OP_INS_SHIFT,
		OP_INS_PUT,
		OP_INS_FIX,
		OP_REM_FOLD,
		OP_REM_SHIFT,
		OP_REM_DONE,
		OP_LIVE_INC,
		OP_LIVE_DEC,
		OP_RDY_MARK,
		OP_IDX_INC,
		OP_IDX_CLR
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic from_tick;
	} dp_cmd_t;

	typedef struct packed {
		logic count_zero;
		logic full;
		logic scan_go;
		logic shift_go;
		logic ins_fix;
		logic rem_more;
		logic idx_in;
		logic idx_zero_delta;
		logic idx_ready;
		logic idx_periodic;
		logic idx_match;
		logic head_ready;
		logic head_periodic;
		logic head_delta_zero;
		logic can_insert;
	} dp_stat_t;

endpackage

@@ sv/dlts_datapath.sv @@
// Entry storage and arithmetic of the delta list scheduler.
// Depends on dlts_pkg; driven by dlts_ctrl commands.
module dlts_datapath
	import dlts_pkg::*;
#(
	parameter int MAX_TASKS = 16
) (
	input logic clk,
	input logic arst_n,
	input dp_cmd_t cmd,
	input logic [IdW-1:0] in_id,
	input logic [DelayW-1:0] in_delay,
	input logic [DelayW-1:0] in_period,
	output dp_stat_t stat,
	output logic [IdW-1:0] head_id
);

	localparam int IW = (MAX_TASKS <= 1) ? 1 : $clog2(MAX_TASKS);
	localparam int CW = $clog2(MAX_TASKS + 1);
	localparam logic [CW-1:0] CntMax = CW'(MAX_TASKS);

	logic [DelayW-1:0] delta_q [MAX_TASKS];
	logic [DelayW-1:0] period_q [MAX_TASKS];
	logic [IdW-1:0] task_q [MAX_TASKS];
	logic [MAX_TASKS-1:0] ready_q;
	logic [CW-1:0] count_q, live_q;
	logic [CW-1:0] idx_q;     // tick or delete scan position
	logic [CW-1:0] pos_q;     // insert or remove position
	logic [CW-1:0] sh_q;      // shift cursor
	logic [DelayW-1:0] d_q;   // remaining insert delay
	logic [IdW-1:0] ins_id_q;
	logic [DelayW-1:0] ins_per_q;

	logic [IW-1:0] idx_a, pos_a, pos1_a, sh_a, shm1_a;
	logic idx_in, pos_in, pos1_in;
	logic [DelayW:0] fold_sum;

	assign idx_a = idx_q[IW-1:0];
	assign pos_a = pos_q[IW-1:0];
	assign pos1_a = IW'(pos_q + 1'b1);
	assign sh_a = sh_q[IW-1:0];
	assign shm1_a = IW'(sh_q - 1'b1);
	assign idx_in = idx_q < count_q;
	assign pos_in = pos_q < count_q;
	assign pos1_in = (pos_q + 1'b1) < count_q;
	assign fold_sum = {1'b0, delta_q[pos1_a]} + {1'b0, delta_q[pos_a]};

	always_comb begin
		stat.count_zero = count_q == '0;
		stat.full = (live_q >= CntMax) || (count_q >= CntMax);
		stat.can_insert = count_q < CntMax;
		stat.scan_go = pos_in && (delta_q[pos_a] < d_q);
		stat.shift_go = sh_q > pos_q;
		stat.ins_fix = pos1_in;
		stat.rem_more = (sh_q + 1'b1) < count_q;
		stat.idx_in = idx_in;
		stat.idx_zero_delta = delta_q[idx_a] == '0;
		stat.idx_ready = ready_q[idx_a];
		stat.idx_periodic = period_q[idx_a] != '0;
		stat.idx_match = task_q[idx_a] == in_id;
		stat.head_ready = ready_q[0];
		stat.head_periodic = period_q[0] != '0;
		stat.head_delta_zero = delta_q[0] == '0;
	end
	assign head_id = task_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_TASKS; i++) begin
				delta_q[i] <= '0;
				period_q[i] <= '0;
				task_q[i] <= '0;
			end
			ready_q <= '0;
			count_q <= '0;
			live_q <= '0;
			idx_q <= '0;
			pos_q <= '0;
			sh_q <= '0;
			d_q <= '0;
			ins_id_q <= '0;
			ins_per_q <= '0;
		end else begin
			case (cmd.op)
				OP_LOAD: begin
					idx_q <= '0;
					pos_q <= '0;
				end
				OP_TICK_DEC: delta_q[0] <= delta_q[0] - 1'b1;
				OP_INS_SETUP: begin
					pos_q <= '0;
					if (cmd.from_tick) begin
						d_q <= period_q[idx_a];
						ins_per_q <= period_q[idx_a];
						ins_id_q <= task_q[idx_a];
					end else begin
						d_q <= in_delay;
						ins_per_q <= in_period;
						ins_id_q <= in_id;
					end
				end
				OP_INS_SCAN: begin
					d_q <= d_q - delta_q[pos_a];
					pos_q <= pos_q + 1'b1;
				end
				OP_INS_SHIFT: begin
					delta_q[sh_a] <= delta_q[shm1_a];
					period_q[sh_a] <= period_q[shm1_a];
					task_q[sh_a] <= task_q[shm1_a];
					ready_q[sh_a] <= ready_q[shm1_a];
					sh_q <= sh_q - 1'b1;
				end
				OP_INS_PUT: begin
					delta_q[pos_a] <= d_q;
					period_q[pos_a] <= ins_per_q;
					task_q[pos_a] <= ins_id_q;
					ready_q[pos_a] <= 1'b0;
					count_q <= count_q + 1'b1;
				end
				OP_INS_FIX: delta_q[pos1_a] <= delta_q[pos1_a] - d_q;
				OP_REM_FOLD: begin
					if (fold_sum[DelayW])
						delta_q[pos1_a] <= DelayMax;
					else
						delta_q[pos1_a] <= fold_sum[DelayW-1:0];
					sh_q <= pos_q;
				end
				OP_REM_SHIFT: begin
					delta_q[sh_a] <= delta_q[IW'(sh_q + 1'b1)];
					period_q[sh_a] <= period_q[IW'(sh_q + 1'b1)];
					task_q[sh_a] <= task_q[IW'(sh_q + 1'b1)];
					ready_q[sh_a] <= ready_q[IW'(sh_q + 1'b1)];
					sh_q <= sh_q + 1'b1;
				end
				OP_REM_DONE: begin
					count_q <= count_q - 1'b1;
					ready_q[IW'(count_q - 1'b1)] <= 1'b0;
				end
				OP_LIVE_INC: live_q <= live_q + 1'b1;
				OP_LIVE_DEC: if (live_q != '0) live_q <= live_q - 1'b1;
				OP_RDY_MARK: ready_q[idx_a] <= 1'b1;
				OP_IDX_INC: idx_q <= idx_q + 1'b1;
				OP_IDX_CLR: begin
					pos_q <= idx_q;
					sh_q <= count_q;
				end
				default: ;
			endcase
			// Shift cursor starts at the tail when an insert is set up.
			if (cmd.op == OP_INS_SETUP)
				sh_q <= count_q;
		end
	end

endmodule

@@ sv/dlts_ctrl.sv @@
// Sequencer of the delta list scheduler: walks tick, add, delete, dispatch.
// Depends on dlts_pkg and the assertion macro header.
`include "delta_list_task_scheduler_macros.svh"
module dlts_ctrl
	import dlts_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [1:0] action,
	input dp_stat_t stat,
	input logic [IdW-1:0] head_id,
	output logic busy,
	output dp_cmd_t cmd,
	output logic res_valid,
	output logic [IdW-1:0] res_id,
	output logic res_vld_id,
	output logic res_last,
	output logic [1:0] res_status
);

	typedef enum logic [4:0] {
		S_IDLE,
		S_TICK,
		S_TSCAN,
		S_TSETUP,
		S_ISCAN,
		S_ISHIFT,
		S_IPUT,
		S_IFIX,
		S_IEND,
		S_DSCAN,
		S_RFOLD,
		S_RSHIFT,
		S_RDONE,
		S_PSCAN,
		S_DONE
	} state_t;

	state_t state_q;
	action_t act_q;
	logic [4:0] n_q;          // dispatch result count; add and delete use it as a flag
	logic dec_live_q;         // live count already dropped for the current entry

	// A small lookup of which operation each state drives.
	always_comb begin
		cmd.op = OP_NONE;
		cmd.from_tick = act_q == ACT_TICK;
		case (state_q)
			S_IDLE: cmd.op = start ? OP_LOAD : OP_NONE;
			S_TICK: cmd.op = (!stat.count_zero && !stat.head_delta_zero) ?
				OP_TICK_DEC : OP_NONE;
			S_TSCAN: cmd.op = (stat.idx_in && stat.idx_zero_delta && !stat.idx_ready)
				? OP_RDY_MARK : (stat.idx_in && stat.idx_zero_delta) ? OP_IDX_INC
				: OP_NONE;
			S_TSETUP: cmd.op = stat.idx_periodic ?
				(stat.can_insert ? OP_INS_SETUP : OP_LIVE_DEC) : OP_IDX_INC;
			S_ISCAN: cmd.op = (act_q == ACT_ADD && n_q == '0) ? OP_INS_SETUP :
				stat.scan_go ? OP_INS_SCAN : OP_NONE;
			S_ISHIFT: cmd.op = stat.shift_go ? OP_INS_SHIFT : OP_NONE;
			S_IPUT: cmd.op = OP_INS_PUT;
			S_IFIX: cmd.op = stat.ins_fix ? OP_INS_FIX : OP_NONE;
			S_IEND: cmd.op = (act_q == ACT_ADD) ? OP_LIVE_INC : OP_IDX_INC;
			S_DSCAN: cmd.op = !stat.idx_in ? OP_NONE : stat.idx_match ?
				((stat.idx_ready && stat.idx_periodic) ? OP_IDX_CLR :
				(dec_live_q ? OP_IDX_CLR : OP_LIVE_DEC)) : OP_IDX_INC;
			S_RFOLD: cmd.op = stat.ins_fix ? OP_REM_FOLD : OP_NONE;
			S_RSHIFT: cmd.op = stat.rem_more ? OP_REM_SHIFT : OP_REM_DONE;
			S_PSCAN: cmd.op = (!stat.count_zero && stat.head_ready &&
				n_q < 5'(ResultMax)) ?
				(stat.head_periodic || dec_live_q ? OP_IDX_CLR : OP_LIVE_DEC)
				: OP_NONE;
			default: cmd.op = OP_NONE;
		endcase
	end

	// One clocked block holds state and the registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			act_q <= ACT_TICK;
			n_q <= '0;
			dec_live_q <= 1'b0;
			busy <= 1'b0;
			res_valid <= 1'b0;
			res_id <= '0;
			res_vld_id <= 1'b0;
			res_last <= 1'b0;
			res_status <= ST_OK;
		end else begin
			res_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						act_q <= action_t'(action);
						busy <= 1'b1;
						n_q <= '0;
						dec_live_q <= 1'b0;
						case (action_t'(action))
							ACT_TICK: state_q <= S_TICK;
							ACT_ADD: state_q <= S_ISCAN;
							ACT_DEL: state_q <= S_DSCAN;
							default: state_q <= S_PSCAN;
						endcase
					end
				end
				S_TICK: begin
					if (!stat.count_zero && stat.head_delta_zero)
						state_q <= S_TSCAN;
					else
						state_q <= S_DONE;
				end
				S_TSCAN: begin
					if (!(stat.idx_in && stat.idx_zero_delta))
						state_q <= S_DONE;
					else if (!stat.idx_ready)
						state_q <= S_TSETUP;
				end
				S_TSETUP: begin
					if (stat.idx_periodic && stat.can_insert)
						state_q <= S_ISCAN;
					else if (stat.idx_periodic)
						state_q <= S_TSCAN;
					else
						state_q <= S_TSCAN;
				end
				S_ISCAN: begin
					if (act_q == ACT_ADD && n_q == '0) begin
						// First visit of an add: report full or set up.
						if (stat.full) begin
							res_valid <= 1'b1;
							res_id <= '0;
							res_vld_id <= 1'b0;
							res_last <= 1'b1;
							res_status <= ST_FULL;
							state_q <= S_IDLE;
							busy <= 1'b0;
						end
						n_q <= 5'd1;
					end else if (!stat.scan_go) begin
						state_q <= S_ISHIFT;
					end
				end
				S_ISHIFT: if (!stat.shift_go) state_q <= S_IPUT;
				S_IPUT: state_q <= S_IFIX;
				S_IFIX: state_q <= S_IEND;
				S_IEND: state_q <= (act_q == ACT_ADD) ? S_DONE : S_TSCAN;
				S_DSCAN: begin
					if (stat.count_zero && n_q == '0) begin
						res_valid <= 1'b1;
						res_id <= '0;
						res_vld_id <= 1'b0;
						res_last <= 1'b1;
						res_status <= ST_EMPTY;
						state_q <= S_IDLE;
						busy <= 1'b0;
					end else if (!stat.idx_in) begin
						state_q <= S_DONE;
					end else if (stat.idx_match) begin
						if (cmd.op == OP_LIVE_DEC)
							dec_live_q <= 1'b1;
						else begin
							dec_live_q <= 1'b0;
							n_q <= 5'd1;
							state_q <= S_RFOLD;
						end
					end
				end
				S_RFOLD: state_q <= S_RSHIFT;
				S_RSHIFT: begin
					if (!stat.rem_more)
						state_q <= (act_q == ACT_DEL) ? S_DSCAN : S_PSCAN;
				end
				S_PSCAN: begin
					if (!stat.count_zero && stat.head_ready && n_q < 5'(ResultMax)) begin
						if (cmd.op == OP_LIVE_DEC)
							dec_live_q <= 1'b1;
						else begin
							dec_live_q <= 1'b0;
							res_valid <= 1'b1;
							res_id <= head_id;
							res_vld_id <= 1'b1;
							res_status <= ST_OK;
							n_q <= n_q + 1'b1;
							res_last <= 1'b0;
							state_q <= S_RFOLD;
						end
					end else begin
						if (n_q == '0) begin
							res_valid <= 1'b1;
							res_id <= '0;
							res_vld_id <= 1'b0;
						end else begin
							// Mark the previous popped result as the last one.
							res_valid <= 1'b0;
						end
						res_last <= 1'b1;
						res_status <= ST_OK;
						state_q <= S_IDLE;
						busy <= 1'b0;
					end
				end
				S_DONE: begin
					res_valid <= 1'b1;
					res_id <= '0;
					res_vld_id <= 1'b0;
					res_last <= 1'b1;
					res_status <= ST_OK;
					state_q <= S_IDLE;
					busy <= 1'b0;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`DLTS_ASSERT_IMP(a_res_busy, clk, arst_n, res_valid && !res_last, busy, "pop not final while idle")
	`DLTS_ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy, "start did not raise busy")
	`DLTS_ASSERT_IMP(a_status_ok, clk, arst_n, res_valid && res_vld_id, res_status == ST_OK, "pop with error status")

endmodule

@@ sv/delta_list_task_scheduler.sv @@
// Top level of the delta list task scheduler.
// Depends on dlts_pkg, dlts_ctrl and dlts_datapath.
//
// Usage: raise start with action and operands while busy is low; the command
// is taken at that edge and busy rises until it is done. Every transfer out is
// shown for one cycle with result_valid and cannot be held off by the
// receiver. Tick, add and delete give one result marked last. Dispatch gives
// one result per popped ready task, up to sixteen. Because results of a
// dispatch are registered one pop behind, the last flag of a dispatch is
// carried by the final popped result: each popped id is presented when the
// pop of the next one is decided. Insert and delete walk the entry store one
// slot per cycle through a single shared shift unit, so a periodic tick that
// re-queues several tasks costs one walk per task.
module delta_list_task_scheduler
	import dlts_pkg::*;
#(
	parameter int MAX_TASKS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [1:0] action,
	input logic [IdW-1:0] task_id,
	input logic [DelayW-1:0] first_delay,
	input logic [DelayW-1:0] repeat_period,
	output logic result_valid,
	output logic [IdW-1:0] ready_id,
	output logic ready_valid,
	output logic last,
	output logic [1:0] status
);

	dp_cmd_t cmd;
	dp_stat_t stat;
	logic [IdW-1:0] head_id;
	logic c_valid, c_vld_id, c_last;
	logic [IdW-1:0] c_id;
	logic [1:0] c_status;
	logic [IdW-1:0] id_q;
	logic [DelayW-1:0] delay_q, period_q;

	// Hold the operands of the accepted command.
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			id_q <= task_id;
			delay_q <= first_delay;
			period_q <= repeat_period;
		end
	end

	dlts_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .action(action),
		.stat(stat), .head_id(head_id), .busy(busy), .cmd(cmd),
		.res_valid(c_valid), .res_id(c_id), .res_vld_id(c_vld_id),
		.res_last(c_last), .res_status(c_status)
	);

	dlts_datapath #(.MAX_TASKS(MAX_TASKS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.in_id(busy ? id_q : task_id),
		.in_delay(busy ? delay_q : first_delay),
		.in_period(busy ? period_q : repeat_period),
		.stat(stat), .head_id(head_id)
	);

	// A popped id waits here until the next decision tells whether it is last.
	logic pend_q;
	logic [IdW-1:0] pend_id_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			pend_id_q <= '0;
		end else if (c_valid && c_vld_id) begin
			pend_q <= 1'b1;
			pend_id_q <= c_id;
		end else if (pend_q && c_last) begin
			pend_q <= 1'b0;
		end
	end

	always_comb begin
		result_valid = 1'b0;
		ready_id = '0;
		ready_valid = 1'b0;
		last = 1'b0;
		status = ST_OK;
		if (pend_q && ((c_valid && c_vld_id) || (!c_valid && c_last && !busy))) begin
			result_valid = 1'b1;
			ready_id = pend_id_q;
			ready_valid = 1'b1;
			last = !(c_valid && c_vld_id);
		end else if (c_valid && !c_vld_id) begin
			result_valid = 1'b1;
			last = c_last;
			status = c_status;
		end
	end

endmodule

@@ sim/delta_list_task_scheduler_tb.sv @@
// Self-checking testbench for the delta list task scheduler.
// Depends on dlts_pkg and delta_list_task_scheduler; drives commands and
// checks every result against a predictor of the timer queue.
module delta_list_task_scheduler_tb;
	import dlts_pkg::*;

	localparam int Slots = 16;
	localparam int DrainCycles = 400;

	// One expected result of a command.
	typedef struct {
		logic [IdW-1:0] id;
		logic valid;
		logic is_last;
		status_t st;
	} sched_result_t;

	// One row of the directed table. When has_known is set, the row's
	// expected result (always a single one) has its status typed in by hand,
	// and that status is compared with the predictor's answer as well.
	typedef struct {
		action_t act;
		logic [IdW-1:0] id;
		logic [DelayW-1:0] dly;
		logic [DelayW-1:0] per;
		logic has_known;
		status_t known_st;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [1:0] action;
	logic [IdW-1:0] task_id;
	logic [DelayW-1:0] first_delay;
	logic [DelayW-1:0] repeat_period;
	logic result_valid;
	logic [IdW-1:0] ready_id;
	logic ready_valid;
	logic last;
	logic [1:0] status;

	delta_list_task_scheduler #(.MAX_TASKS(Slots)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.task_id(task_id),
		.first_delay(first_delay),
		.repeat_period(repeat_period),
		.result_valid(result_valid),
		.ready_id(ready_id),
		.ready_valid(ready_valid),
		.last(last),
		.status(status)
	);

	// Predictor copy of the timer queue.
	logic [DelayW-1:0] q_delta [Slots];
	logic [DelayW-1:0] q_period [Slots];
	logic [IdW-1:0] q_task [Slots];
	logic q_ready [Slots];
	int q_count;
	int q_live;

	// Results still owed by the block, oldest first.
	sched_result_t pending_results [$];
	int error_count;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard limit: at most about 700 commands with their idle gaps stay far
	// below this.
	initial begin
		#40000000;
		$display("delta_list_task_scheduler: mismatch");
		$finish;
	end

	task automatic report_mismatch(input string what);
		error_count++;
		$display("ERROR at %0t: %s", $realtime, what);
	endtask

	function automatic void drop_live_task();
		if (q_live > 0)
			q_live--;
	endfunction

	function automatic bit queue_insert(input logic [IdW-1:0] id,
			input logic [DelayW-1:0] dly, input logic [DelayW-1:0] per);
		int pos;
		logic [DelayW-1:0] rest;
		pos = 0;
		rest = dly;
		if (q_count >= Slots)
			return 0;
		while (pos < q_count && q_delta[pos] < rest) begin
			rest -= q_delta[pos];
			pos++;
		end
		for (int j = q_count; j > pos; j--) begin
			q_delta[j] = q_delta[j-1];
			q_period[j] = q_period[j-1];
			q_task[j] = q_task[j-1];
			q_ready[j] = q_ready[j-1];
		end
		q_delta[pos] = rest;
		q_period[pos] = per;
		q_task[pos] = id;
		q_ready[pos] = 1'b0;
		q_count++;
		if (pos + 1 < q_count)
			q_delta[pos+1] -= rest;
		return 1;
	endfunction

	// Removal folds the removed delta into the successor, saturating.
	function automatic void queue_remove(input int pos);
		logic [DelayW:0] sum;
		if (pos + 1 < q_count) begin
			sum = {1'b0, q_delta[pos+1]} + {1'b0, q_delta[pos]};
			q_delta[pos+1] = sum[DelayW] ? DelayMax : sum[DelayW-1:0];
		end
		for (int j = pos; j + 1 < q_count; j++) begin
			q_delta[j] = q_delta[j+1];
			q_period[j] = q_period[j+1];
			q_task[j] = q_task[j+1];
			q_ready[j] = q_ready[j+1];
		end
		q_count--;
		q_ready[q_count] = 1'b0;
	endfunction

	function automatic void push_result(input logic [IdW-1:0] id, input logic v,
			input logic l, input status_t st);
		sched_result_t r;
		r.id = id;
		r.valid = v;
		r.is_last = l;
		r.st = st;
		pending_results.push_back(r);
	endfunction

	// Applies one command to the predictor and queues what it yields.
	function automatic void predict_command(input action_t act, input logic [IdW-1:0] id,
			input logic [DelayW-1:0] dly, input logic [DelayW-1:0] per);
		int i;
		int popped;
		case (act)
			ACT_TICK: begin
				if (q_count > 0) begin
					if (q_delta[0] != 0) begin
						q_delta[0]--;
					end else begin
						// Re-queued tasks land behind the zero run, so the
						// walk still ends at the first nonzero delta.
						for (i = 0; i < q_count && q_delta[i] == 0; i++) begin
							if (!q_ready[i]) begin
								q_ready[i] = 1'b1;
								if (q_period[i] != 0)
									if (!queue_insert(q_task[i], q_period[i], q_period[i]))
										drop_live_task();
							end
						end
					end
				end
				push_result('0, 1'b0, 1'b1, ST_OK);
			end
			ACT_ADD: begin
				if (q_live >= Slots || q_count >= Slots) begin
					push_result('0, 1'b0, 1'b1, ST_FULL);
				end else begin
					void'(queue_insert(id, dly, per));
					q_live++;
					push_result('0, 1'b0, 1'b1, ST_OK);
				end
			end
			ACT_DEL: begin
				if (q_count == 0) begin
					push_result('0, 1'b0, 1'b1, ST_EMPTY);
				end else begin
					i = 0;
					while (i < q_count) begin
						if (q_task[i] == id) begin
							// A ready periodic entry already has its next run queued.
							if (!(q_ready[i] && q_period[i] != 0))
								drop_live_task();
							queue_remove(i);
						end else begin
							i++;
						end
					end
					push_result('0, 1'b0, 1'b1, ST_OK);
				end
			end
			default: begin
				popped = 0;
				while (popped < ResultMax && q_count > 0 && q_ready[0]) begin
					if (q_period[0] == 0)
						drop_live_task();
					push_result(q_task[0], 1'b1, 1'b0, ST_OK);
					queue_remove(0);
					popped++;
				end
				if (popped == 0)
					push_result('0, 1'b0, 1'b1, ST_OK);
				else
					pending_results[$].is_last = 1'b1;
			end
		endcase
	endfunction

	// Every result strobe is matched with the oldest expectation.
	always @(posedge clk) begin
		sched_result_t exp_r;
		if (arst_n && result_valid) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result id=%0d", ready_id));
			end else begin
				exp_r = pending_results.pop_front();
				if (ready_id !== exp_r.id)
					report_mismatch($sformatf("ready_id %0d, want %0d", ready_id, exp_r.id));
				if (ready_valid !== exp_r.valid)
					report_mismatch($sformatf("ready_valid %b, want %b",
						ready_valid, exp_r.valid));
				if (last !== exp_r.is_last)
					report_mismatch($sformatf("last %b, want %b", last, exp_r.is_last));
				if (status !== exp_r.st)
					report_mismatch($sformatf("status %0d, want %0d", status, exp_r.st));
			end
		end
	end

	int sender_gap;
	bit quiet_tail;

	// Issues one command: optional idle burst, then hold start until taken.
	// Start stays high after the transfer so commands can follow back to
	// back; whoever pauses the stream drops it first.
	task automatic send_command(input action_t act, input logic [IdW-1:0] id,
			input logic [DelayW-1:0] dly, input logic [DelayW-1:0] per);
		if (!quiet_tail && $urandom_range(0, 3) == 0) begin
			sender_gap = $urandom_range(1, 10);
			start <= 1'b0;
			repeat (sender_gap) @(posedge clk);
		end
		start <= 1'b1;
		action <= act;
		task_id <= id;
		first_delay <= dly;
		repeat_period <= per;
		@(posedge clk);
		while (busy) @(posedge clk);
		// The command transfers at this edge; predict before its results.
		predict_command(act, id, dly, per);
	endtask

	// Ids from a small pool so deletes and repeats hit live entries.
	function automatic logic [IdW-1:0] pick_id();
		if ($urandom_range(0, 7) == 0)
			return IdW'($urandom);
		return IdW'($urandom_range(0, 5)) | ($urandom_range(0, 1) ? 8'hF0 : 8'h00);
	endfunction

	function automatic logic [DelayW-1:0] pick_delay();
		case ($urandom_range(0, 9))
			0: return DelayMax;
			1: return DelayW'($urandom);
			2: return '0;
			default: return DelayW'($urandom_range(0, 6));
		endcase
	endfunction

	stim_row_t directed_rows [$];

	function automatic stim_row_t make_row(input action_t a, input logic [IdW-1:0] id,
			input logic [DelayW-1:0] d, input logic [DelayW-1:0] p,
			input logic k, input status_t st);
		stim_row_t r;
		r.act = a;
		r.id = id;
		r.dly = d;
		r.per = p;
		r.has_known = k;
		r.known_st = st;
		return r;
	endfunction

	initial begin
		action_t act;
		int n;
		arst_n = 1'b0;
		start = 1'b0;
		action = ACT_TICK;
		task_id = '0;
		first_delay = '0;
		repeat_period = '0;
		error_count = 0;
		quiet_tail = 0;
		q_count = 0;
		q_live = 0;
		for (int i = 0; i < Slots; i++) begin
			q_delta[i] = '0;
			q_period[i] = '0;
			q_task[i] = '0;
			q_ready[i] = 1'b0;
		end

		// Directed table: empty queue cases, extremes of every field, a
		// fold that reaches DelayMax, a periodic run, a full queue and a long ready run.
		directed_rows.push_back(make_row(ACT_DEL, 8'd3, '0, '0, 1, ST_EMPTY));
		directed_rows.push_back(make_row(ACT_TICK, '0, '0, '0, 1, ST_OK));
		directed_rows.push_back(make_row(ACT_DISP, '0, '0, '0, 1, ST_OK));
		directed_rows.push_back(make_row(ACT_ADD, 8'hFF, DelayMax, DelayMax, 1, ST_OK));
		directed_rows.push_back(make_row(ACT_ADD, 8'h00, '0, 24'd2, 1, ST_OK));
		directed_rows.push_back(make_row(ACT_ADD, 8'h55, 24'h800000, '0, 1, ST_OK));
		directed_rows.push_back(make_row(ACT_DEL, 8'h77, '0, '0, 1, ST_OK));
		directed_rows.push_back(make_row(ACT_DEL, 8'h55, '0, '0, 1, ST_OK));
		directed_rows.push_back(make_row(ACT_TICK, '0, '0, '0, 0, ST_OK));
		directed_rows.push_back(make_row(ACT_DISP, '0, '0, '0, 0, ST_OK));
		directed_rows.push_back(make_row(ACT_TICK, '0, '0, '0, 0, ST_OK));
		directed_rows.push_back(make_row(ACT_TICK, '0, '0, '0, 0, ST_OK));
		directed_rows.push_back(make_row(ACT_TICK, '0, '0, '0, 0, ST_OK));
		directed_rows.push_back(make_row(ACT_DEL, 8'h00, '0, '0, 0, ST_OK));
		directed_rows.push_back(make_row(ACT_DISP, '0, '0, '0, 0, ST_OK));
		// Fill with zero-delay one-shots until the add reports full.
		for (int i = 0; i < 16; i++)
			directed_rows.push_back(make_row(ACT_ADD, 8'(8'hA0 + i), '0, '0, 0, ST_OK));
		directed_rows.push_back(make_row(ACT_ADD, 8'h11, 24'd1, '0, 1, ST_FULL));
		directed_rows.push_back(make_row(ACT_TICK, '0, '0, '0, 0, ST_OK));
		directed_rows.push_back(make_row(ACT_DISP, '0, '0, '0, 0, ST_OK));
		directed_rows.push_back(make_row(ACT_DISP, '0, '0, '0, 0, ST_OK));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r]) begin
			send_command(directed_rows[r].act, directed_rows[r].id,
				directed_rows[r].dly, directed_rows[r].per);
			if (directed_rows[r].has_known && pending_results.size() > 0 &&
					pending_results[$].st != directed_rows[r].known_st)
				report_mismatch($sformatf("row %0d: predictor status differs", r));
		end
		// Clear the queue so the random part starts from a light load.
		for (int i = 0; i < 256; i += 1)
			if (q_count > 0)
				send_command(ACT_DEL, IdW'(i), '0, '0);

		// Random part: mostly ticks and dispatches around a moderate
		// population, with bursts of adds to reach full and deletes.
		for (n = 0; n < 410; n++) begin
			if (n == 200) begin
				// Hold off until every owed result has come.
				start <= 1'b0;
				while (pending_results.size() != 0) @(posedge clk);
			end
			if (n >= 360)
				quiet_tail = 1;
			case ($urandom_range(0, 9))
				0, 1, 2: act = ACT_TICK;
				3, 4: act = ACT_ADD;
				5: act = (n % 60 < 10) ? ACT_ADD : ACT_DEL;
				6: act = ACT_DEL;
				default: act = ACT_DISP;
			endcase
			send_command(act, pick_id(), pick_delay(),
				$urandom_range(0, 2) == 0 ? '0 : pick_delay());
		end
		start <= 1'b0;

		n = 0;
		while (pending_results.size() != 0 && n < 100000) begin
			@(posedge clk);
			n++;
		end
		repeat (DrainCycles) @(posedge clk);
		if (error_count == 0 && pending_results.size() == 0)
			$display("delta_list_task_scheduler: match");
		else
			$display("delta_list_task_scheduler: mismatch");
		$finish;
	end

endmodule
